// File: hdl/csw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_pkg
// Shared types, operation and status codes for the semaphore wait table.
// ----------------------------------------------------------------------------
package csw_pkg;

   localparam int RESOURCES_DEF = 16;
   localparam int WAITERS_DEF   = 16;

   localparam int OP_W   = 3;
   localparam int IDX_W  = 4;
   localparam int CNT8_W = 8;
   localparam int ID_W   = 31;
   localparam int SEM_W  = 16;
   localparam int ST_W   = 2;

   localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
   localparam logic [OP_W-1:0] OP_ACQUIRE = 3'd2;
   localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd3;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd4;
   localparam logic [OP_W-1:0] OP_CANCEL  = 3'd5;

   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_REFUSED = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
   localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic              bad_op;
      logic [IDX_W-1:0]  idx;
      logic [CNT8_W-1:0] count;
      logic              xfer;
      logic [ID_W-1:0]   id;
   } item_type;

   // Semaphore step of plus or minus one, saturating at the 16-bit limits.
   function automatic logic signed [SEM_W-1:0] sem_step(input logic signed [SEM_W-1:0] s,
                                                        input logic up);
      logic signed [SEM_W:0] sum;
      sum = up ? ({s[SEM_W-1], s} + 17'sd1) : ({s[SEM_W-1], s} - 17'sd1);
      if (sum > 17'sd32767) begin
         return 16'sh7FFF;
      end else if (sum < -17'sd32768) begin
         return 16'sh8000;
      end else begin
         return sum[SEM_W-1:0];
      end
   endfunction

endpackage

// File: hdl/csw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_front
// Accepts transactions, classifies the operation and queues them.
// ----------------------------------------------------------------------------
module csw_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [csw_pkg::OP_W-1:0]    req_op,
   input  logic [csw_pkg::IDX_W-1:0]   req_resource_index,
   input  logic [csw_pkg::CNT8_W-1:0]  req_instance_count,
   input  logic                        req_with_transfer,
   input  logic [csw_pkg::ID_W-1:0]    req_waiter_id,
   output logic                        q_valid,
   output csw_pkg::item_type           q_item,
   input  logic                        q_pop
);
   import csw_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;
   item_type   new_item;

   assign busy    = reset || (fill_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (fill_ff != 2'd0);
   assign pop     = q_pop && q_valid;
   assign q_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      new_item.op     = req_op;
      new_item.bad_op = (req_op > OP_CANCEL);
      new_item.idx    = req_resource_index;
      new_item.count  = req_instance_count;
      new_item.xfer   = req_with_transfer;
      new_item.id     = req_waiter_id;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// File: hdl/csw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_back
// Executes queued operations against the resource and waiter memories.
// ----------------------------------------------------------------------------
module csw_back #(
   parameter int RESOURCES = csw_pkg::RESOURCES_DEF,
   parameter int WAITERS   = csw_pkg::WAITERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  csw_pkg::item_type                 q_item,
   output logic                              q_pop,
   output logic                              rsp_valid,
   output logic [csw_pkg::ST_W-1:0]          rsp_status,
   output logic [csw_pkg::IDX_W-1:0]         rsp_result_index,
   output logic [csw_pkg::CNT8_W-1:0]        rsp_available_now,
   output logic signed [csw_pkg::SEM_W-1:0]  rsp_semaphore_now,
   output logic [csw_pkg::ID_W-1:0]          rsp_head_waiter,
   output logic                              rsp_waiters_empty
);
   import csw_pkg::*;

   localparam int RA_W  = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
   localparam int CNT_W = $clog2(RESOURCES + 1);
   localparam int SL_W  = $clog2(WAITERS);
   localparam int LEN_W = $clog2(WAITERS + 1);
   localparam int CMP_W = 10;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_META = 3'd1;
   localparam logic [2:0] S_HEAD = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_SHRD = 3'd4;
   localparam logic [2:0] S_SHWR = 3'd5;

   typedef struct packed {
      logic [CNT8_W-1:0]       total;
      logic [CNT8_W-1:0]       free;
      logic signed [SEM_W-1:0] sem;
      logic [LEN_W-1:0]        len;
   } meta_type;

   meta_type          meta_mem [RESOURCES];
   logic [ID_W-1:0]   slot_mem [RESOURCES*(2**SL_W)];
   meta_type          meta_q;
   logic [ID_W-1:0]   slot_q;

   logic [2:0]        state_ff, state_in;
   item_type          item_ff, item_in;
   meta_type          meta_ff, meta_in;
   logic [SL_W-1:0]   pos_ff, pos_in;
   logic [ID_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]  total_ff, total_in;

   logic [RA_W-1:0]      item_ra;
   logic [RA_W-1:0]      meta_ra, meta_wa;
   logic                 meta_we;
   meta_type             meta_wd;
   logic [RA_W+SL_W-1:0] slot_ra, slot_wa;
   logic                 slot_we;
   logic [ID_W-1:0]      slot_wd;
   meta_type             m2;
   logic [SL_W-1:0]      pos_next;
   logic                 pos_last;

   logic                    do_rsp;
   logic [ST_W-1:0]         r_status;
   logic [IDX_W-1:0]        r_idx;
   logic [CNT8_W-1:0]       r_free;
   logic signed [SEM_W-1:0] r_sem;
   logic [ID_W-1:0]         r_head;
   logic                    r_empty;

   logic                    rsp_valid_ff;
   logic [ST_W-1:0]         rsp_status_ff;
   logic [IDX_W-1:0]        rsp_idx_ff;
   logic [CNT8_W-1:0]       rsp_free_ff;
   logic signed [SEM_W-1:0] rsp_sem_ff;
   logic [ID_W-1:0]         rsp_head_ff;
   logic                    rsp_empty_ff;

   assign item_ra  = RA_W'(item_ff.idx);
   assign pos_next = SL_W'({1'b0, pos_ff} + 1'b1);
   assign pos_last = (LEN_W'({1'b0, pos_ff}) + LEN_W'(1)) >= meta_ff.len;

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      meta_in  = meta_ff;
      pos_in   = pos_ff;
      head_in  = head_ff;
      total_in = total_ff;
      q_pop    = 1'b0;
      meta_ra  = item_ra;
      meta_we  = 1'b0;
      meta_wa  = item_ra;
      meta_wd  = meta_ff;
      slot_ra  = {item_ra, pos_ff};
      slot_we  = 1'b0;
      slot_wa  = {item_ra, pos_ff};
      slot_wd  = slot_q;
      m2       = meta_q;
      do_rsp   = 1'b0;
      r_status = ST_OK;
      r_idx    = item_ff.idx;
      r_free   = '0;
      r_sem    = '0;
      r_head   = '0;
      r_empty  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               if (q_item.op == OP_CREATE) begin
                  do_rsp = 1'b1;
                  if (total_ff == CNT_W'(RESOURCES)) begin
                     r_status = ST_FULL;
                     r_idx    = '0;
                     r_empty  = 1'b1;
                  end else begin
                     meta_we     = 1'b1;
                     meta_wa     = RA_W'(total_ff);
                     meta_wd.total = q_item.count;
                     meta_wd.free  = q_item.count;
                     meta_wd.sem   = SEM_W'(q_item.count);
                     meta_wd.len   = '0;
                     total_in    = total_ff + CNT_W'(1);
                     r_idx       = IDX_W'(total_ff);
                     r_free      = q_item.count;
                     r_sem       = SEM_W'(q_item.count);
                     r_empty     = 1'b1;
                  end
               end else if (q_item.bad_op ||
                            (CMP_W'(q_item.idx) >= CMP_W'(total_ff))) begin
                  do_rsp   = 1'b1;
                  r_status = ST_UNKNOWN;
                  r_idx    = '0;
               end else begin
                  meta_ra  = RA_W'(q_item.idx);
                  state_in = S_META;
               end
            end
         end
         S_META: begin
            meta_in = meta_q;
            head_in = '0;
            pos_in  = '0;
            m2      = meta_q;
            r_free  = meta_q.free;
            r_sem   = meta_q.sem;
            r_empty = (meta_q.len == '0);
            case (item_ff.op)
               OP_RELEASE: begin
                  if (item_ff.xfer && (meta_q.free < meta_q.total)) begin
                     m2.free = meta_q.free + 8'd1;
                  end
                  m2.sem = sem_step(meta_q.sem, 1'b1);
               end
               OP_ACQUIRE: begin
                  if (item_ff.xfer) begin
                     if (meta_q.free != '0) begin
                        m2.free = meta_q.free - 8'd1;
                     end else begin
                        r_status = ST_REFUSED;
                     end
                  end else begin
                     m2.sem = sem_step(meta_q.sem, 1'b0);
                  end
               end
               OP_ENQUEUE: begin
                  if (item_ff.id == '0) begin
                     r_status = ST_REFUSED;
                  end else if (meta_q.len == LEN_W'(WAITERS)) begin
                     r_status = ST_FULL;
                  end else begin
                     slot_we = 1'b1;
                     slot_wa = {item_ra, SL_W'(meta_q.len)};
                     slot_wd = item_ff.id;
                     m2.len  = meta_q.len + LEN_W'(1);
                  end
               end
               default: begin
                  if (meta_q.len == '0) begin
                     r_status = ST_REFUSED;
                  end else begin
                     slot_ra  = {item_ra, {SL_W{1'b0}}};
                     state_in = (item_ff.op == OP_DEQUEUE) ? S_HEAD : S_SCAN;
                  end
               end
            endcase
            if (state_in == S_META) begin
               do_rsp   = 1'b1;
               state_in = S_IDLE;
               meta_we  = 1'b1;
               meta_wd  = m2;
               r_free   = m2.free;
               r_sem    = m2.sem;
               r_empty  = (m2.len == '0);
            end
         end
         S_HEAD: begin
            head_in  = slot_q;
            state_in = S_SHRD;
         end
         S_SCAN: begin
            if (slot_q == item_ff.id) begin
               state_in = S_SHRD;
            end else if (pos_last) begin
               do_rsp   = 1'b1;
               r_status = ST_REFUSED;
               r_free   = meta_ff.free;
               r_sem    = meta_ff.sem;
               r_empty  = (meta_ff.len == '0);
               state_in = S_IDLE;
            end else begin
               pos_in  = pos_next;
               slot_ra = {item_ra, pos_next};
            end
         end
         S_SHRD: begin
            if (pos_last) begin
               m2 = meta_ff;
               m2.len = meta_ff.len - LEN_W'(1);
               if (item_ff.op == OP_CANCEL) begin
                  m2.sem = sem_step(meta_ff.sem, 1'b1);
               end
               meta_we  = 1'b1;
               meta_wd  = m2;
               do_rsp   = 1'b1;
               r_free   = m2.free;
               r_sem    = m2.sem;
               r_head   = head_ff;
               r_empty  = (m2.len == '0);
               state_in = S_IDLE;
            end else begin
               slot_ra  = {item_ra, pos_next};
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            slot_we  = 1'b1;
            slot_wa  = {item_ra, pos_ff};
            slot_wd  = slot_q;
            pos_in   = pos_next;
            state_in = S_SHRD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= do_rsp;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      meta_ff <= meta_in;
      pos_ff  <= pos_in;
      head_ff <= head_in;
      if (do_rsp) begin
         rsp_status_ff <= r_status;
         rsp_idx_ff    <= r_idx;
         rsp_free_ff   <= r_free;
         rsp_sem_ff    <= r_sem;
         rsp_head_ff   <= r_head;
         rsp_empty_ff  <= r_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      meta_q <= meta_mem[meta_ra];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      slot_q <= slot_mem[slot_ra];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_index  = rsp_idx_ff;
   assign rsp_available_now = rsp_free_ff;
   assign rsp_semaphore_now = rsp_sem_ff;
   assign rsp_head_waiter   = rsp_head_ff;
   assign rsp_waiters_empty = rsp_empty_ff;

endmodule

// File: hdl/counting_semaphore_wait_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_wait_table_core
// Table of counting semaphores, each with an ordered list of waiter ids.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; a two-entry
// queue lets up to two transactions wait while an earlier one executes.
// Every transaction yields exactly one result, shown for one cycle with
// rsp_valid; the receiver cannot stall, so results are never held back.
// Create, unknown ops and uncreated indices are answered from the idle
// state; release, acquire and enqueue first read the resource's metadata.
// Dequeue and cancel walk the waiter list through a waiter memory with one
// read port: a cancel scans slot by slot for its id, a dequeue takes the
// head, and the compaction then moves each later slot down, reading then
// writing it. No clearing pass is needed after reset: each resource keeps
// a list length, so stale slots are never read.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_table_core #(
   parameter int RESOURCES = csw_pkg::RESOURCES_DEF,
   parameter int WAITERS   = csw_pkg::WAITERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [csw_pkg::OP_W-1:0]          req_op,
   input  logic [csw_pkg::IDX_W-1:0]         req_resource_index,
   input  logic [csw_pkg::CNT8_W-1:0]        req_instance_count,
   input  logic                              req_with_transfer,
   input  logic [csw_pkg::ID_W-1:0]          req_waiter_id,
   output logic                              rsp_valid,
   output logic [csw_pkg::ST_W-1:0]          rsp_status,
   output logic [csw_pkg::IDX_W-1:0]         rsp_result_index,
   output logic [csw_pkg::CNT8_W-1:0]        rsp_available_now,
   output logic signed [csw_pkg::SEM_W-1:0]  rsp_semaphore_now,
   output logic [csw_pkg::ID_W-1:0]          rsp_head_waiter,
   output logic                              rsp_waiters_empty
);
   import csw_pkg::*;

   // Queue between the classifying front end and the executing back end.
   logic     q_valid;
   logic     q_pop;
   item_type q_item;

   csw_front u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_resource_index (req_resource_index),
      .req_instance_count (req_instance_count),
      .req_with_transfer  (req_with_transfer),
      .req_waiter_id      (req_waiter_id),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   // The back end owns the resource count, both memories and the result
   // registers.
   csw_back #(
      .RESOURCES (RESOURCES),
      .WAITERS   (WAITERS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_result_index  (rsp_result_index),
      .rsp_available_now (rsp_available_now),
      .rsp_semaphore_now (rsp_semaphore_now),
      .rsp_head_waiter   (rsp_head_waiter),
      .rsp_waiters_empty (rsp_waiters_empty)
   );

endmodule

// File: hdl/csw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csw_checker
// Port-level checks on the semaphore wait table results.
// ----------------------------------------------------------------------------
module csw_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [csw_pkg::ST_W-1:0]          rsp_status,
   input logic [csw_pkg::IDX_W-1:0]         rsp_result_index,
   input logic [csw_pkg::CNT8_W-1:0]        rsp_available_now,
   input logic signed [csw_pkg::SEM_W-1:0]  rsp_semaphore_now,
   input logic [csw_pkg::ID_W-1:0]          rsp_head_waiter,
   input logic                              rsp_waiters_empty
);
   import csw_pkg::*;

   // An unknown resource or op reports nothing but its status.
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_UNKNOWN) |->
         (rsp_result_index == '0) && (rsp_available_now == '0) &&
         (rsp_semaphore_now == '0) && (rsp_head_waiter == '0) && !rsp_waiters_empty)
      else $error("unknown-resource result carries data");

   // A removed waiter only comes with a successful dequeue.
   a_head_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_head_waiter != '0) |-> (rsp_status == ST_OK))
      else $error("head waiter on a failed operation");

   // A full answer with an empty list can only be a full-table create, which
   // reports index zero and no data.
   a_full_create: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) && rsp_waiters_empty |->
         (rsp_result_index == '0) && (rsp_available_now == '0) &&
         (rsp_semaphore_now == '0) && (rsp_head_waiter == '0))
      else $error("full result malformed");

   // Straight after reset nothing is reported.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result straight after reset");

   // No transaction is taken while reset is held.
   a_busy_in_reset: assert property (@(posedge clock)
      reset |-> busy)
      else $error("not busy during reset");

endmodule

bind counting_semaphore_wait_table_core csw_checker u_csw_checker (
   .clock             (clock),
   .reset             (reset),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_result_index  (rsp_result_index),
   .rsp_available_now (rsp_available_now),
   .rsp_semaphore_now (rsp_semaphore_now),
   .rsp_head_waiter   (rsp_head_waiter),
   .rsp_waiters_empty (rsp_waiters_empty)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the counting semaphore wait table core.
// ----------------------------------------------------------------------------
// A short table of directed transactions comes first. Some rows carry their
// expected response typed in, the others are checked against a behavioural
// predictor of the table. A random phase with idle bursts follows, mixing
// list-filling bursts with noise. The run ends with an idle-free phase of
// random transactions. Every response is compared field by field with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;
   import csw_pkg::*;

   localparam int NRES = RESOURCES_DEF;
   localparam int NWAIT = WAITERS_DEF;

   // The two op codes that the block does not define.
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [IDX_W-1:0]  idx;
      logic [CNT8_W-1:0] count;
      logic              xfer;
      logic [ID_W-1:0]   id;
   } request_type;

   typedef struct packed {
      logic [ST_W-1:0]          status;
      logic [IDX_W-1:0]         idx;
      logic [CNT8_W-1:0]        avail;
      logic signed [SEM_W-1:0]  sem;
      logic [ID_W-1:0]          head;
      logic                     empty;
   } outcome_type;

   typedef struct packed {
      request_type rq;
      logic        typed;
      outcome_type want;
   } stim_row_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [OP_W-1:0]          req_op;
   logic [IDX_W-1:0]         req_resource_index;
   logic [CNT8_W-1:0]        req_instance_count;
   logic                     req_with_transfer;
   logic [ID_W-1:0]          req_waiter_id;
   logic                     rsp_valid;
   logic [ST_W-1:0]          rsp_status;
   logic [IDX_W-1:0]         rsp_result_index;
   logic [CNT8_W-1:0]        rsp_available_now;
   logic signed [SEM_W-1:0]  rsp_semaphore_now;
   logic [ID_W-1:0]          rsp_head_waiter;
   logic                     rsp_waiters_empty;

   // Predictor state: a private copy of the whole table.
   int                created;
   int                inst_total [NRES];
   int                inst_free [NRES];
   int                sem_of [NRES];
   logic [ID_W-1:0]   slot_of [NRES][NWAIT];

   outcome_type       pending_outcomes[$];
   int                failures;
   int                responses_seen;
   int                items_sent;
   int                table_full_hits;
   int                list_full_hits;

   counting_semaphore_wait_table_core uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_resource_index (req_resource_index),
      .req_instance_count (req_instance_count),
      .req_with_transfer  (req_with_transfer),
      .req_waiter_id      (req_waiter_id),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_result_index   (rsp_result_index),
      .rsp_available_now  (rsp_available_now),
      .rsp_semaphore_now  (rsp_semaphore_now),
      .rsp_head_waiter    (rsp_head_waiter),
      .rsp_waiters_empty  (rsp_waiters_empty)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard limit on the run, far beyond the slowest correct run.
   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // Saturating step of the semaphore count of one entry.
   function automatic void bump_semaphore(input int r, input int delta);
      int v;
      v = sem_of[r] + delta;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      sem_of[r] = v;
   endfunction

   // Removes the id at position pos, closing the gap and clearing the tail.
   function automatic void close_gap(input int r, input int pos);
      for (int i = pos; i + 1 < NWAIT; i++) slot_of[r][i] = slot_of[r][i + 1];
      slot_of[r][NWAIT - 1] = '0;
   endfunction

   // Applies one transaction to the predicted table and returns its response.
   function automatic outcome_type apply_to_table(input request_type rq);
      outcome_type o;
      int       r;
      int       i;
      logic [ST_W-1:0] st;
      logic [ID_W-1:0] head;
      o = '0;
      st = ST_OK;
      head = '0;
      r = rq.idx;
      if (rq.op == OP_CREATE) begin
         if (created >= NRES) begin
            o.status = ST_FULL;
            o.empty = 1'b1;
            table_full_hits++;
            return o;
         end
         r = created;
         inst_total[r] = rq.count;
         inst_free[r] = rq.count;
         sem_of[r] = rq.count;
         for (i = 0; i < NWAIT; i++) slot_of[r][i] = '0;
         created++;
      end else if (rq.op > OP_CANCEL || r >= created) begin
         o.status = ST_UNKNOWN;
         return o;
      end else begin
         case (rq.op)
            OP_RELEASE: begin
               if (rq.xfer && inst_free[r] < inst_total[r]) inst_free[r]++;
               bump_semaphore(r, 1);
            end
            OP_ACQUIRE: begin
               if (rq.xfer) begin
                  if (inst_free[r] > 0) inst_free[r]--;
                  else st = ST_REFUSED;
               end else begin
                  bump_semaphore(r, -1);
               end
            end
            OP_ENQUEUE: begin
               if (rq.id == '0) begin
                  st = ST_REFUSED;
               end else begin
                  for (i = 0; i < NWAIT && slot_of[r][i] != '0; i++) ;
                  if (i < NWAIT) begin
                     slot_of[r][i] = rq.id;
                  end else begin
                     st = ST_FULL;
                     list_full_hits++;
                  end
               end
            end
            OP_DEQUEUE: begin
               if (slot_of[r][0] == '0) begin
                  st = ST_REFUSED;
               end else begin
                  head = slot_of[r][0];
                  close_gap(r, 0);
               end
            end
            default: begin
               st = ST_REFUSED;
               for (i = 0; i < NWAIT && slot_of[r][i] != '0; i++) begin
                  if (slot_of[r][i] == rq.id) begin
                     bump_semaphore(r, 1);
                     close_gap(r, i);
                     st = ST_OK;
                     break;
                  end
               end
            end
         endcase
      end
      o.status = st;
      o.idx = r[IDX_W-1:0];
      o.avail = inst_free[r][CNT8_W-1:0];
      o.sem = sem_of[r][SEM_W-1:0];
      o.head = head;
      o.empty = (slot_of[r][0] == '0);
      return o;
   endfunction

   function automatic stim_row_type row(input logic [OP_W-1:0] op, input int idx,
                                        input int count, input bit xfer,
                                        input logic [ID_W-1:0] id, input bit typed,
                                        input outcome_type want);
      stim_row_type s;
      s.rq.op = op;
      s.rq.idx = idx[IDX_W-1:0];
      s.rq.count = count[CNT8_W-1:0];
      s.rq.xfer = xfer;
      s.rq.id = id;
      s.typed = typed;
      s.want = want;
      return s;
   endfunction

   // Presents one transaction after an optional idle gap and holds it until
   // busy is low. Inputs move only on the falling edge; busy is stable then.
   task automatic issue(input request_type rq, input bit typed,
                        input outcome_type want, input int gap);
      outcome_type predicted;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_op <= rq.op;
      req_resource_index <= rq.idx;
      req_instance_count <= rq.count;
      req_with_transfer <= rq.xfer;
      req_waiter_id <= rq.id;
      #1;
      while (busy) @(negedge clock);
      @(posedge clock);
      predicted = apply_to_table(rq);
      pending_outcomes.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // Random idle bursts, never inside a quiet stretch; the stretches come and go.
   function automatic int pick_gap(input bit quiet_stretch);
      if (quiet_stretch || $urandom_range(0, 3) != 0) return 0;
      return $urandom_range(1, 5);
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return '0;
      if (sel < 3) return ID_W'($urandom());
      return ID_W'($urandom_range(1, 6));
   endfunction

   function automatic int pick_index();
      if (created == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 15);
      return $urandom_range(0, created - 1);
   endfunction

   function automatic request_type random_request();
      request_type rq;
      int       w;
      rq.idx = IDX_W'(pick_index());
      rq.count = ($urandom_range(0, 3) == 0) ? 8'(($urandom_range(0, 2) == 0) ? 0 : 255)
                                              : 8'($urandom_range(0, 255));
      rq.xfer = 1'($urandom_range(0, 1));
      rq.id = pick_id();
      w = $urandom_range(0, 99);
      if (w < 8) rq.op = OP_CREATE;
      else if (w < 23) rq.op = OP_RELEASE;
      else if (w < 43) rq.op = OP_ACQUIRE;
      else if (w < 68) rq.op = OP_ENQUEUE;
      else if (w < 80) rq.op = OP_DEQUEUE;
      else if (w < 95) rq.op = OP_CANCEL;
      else rq.op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      return rq;
   endfunction

   // Response checker: every strobed response must match the oldest
   // prediction still outstanding.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         responses_seen++;
         if (pending_outcomes.size() == 0) begin
            $error("response with no transaction outstanding");
            failures++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_result_index !== want.idx) begin
               $error("result_index expected %0d got %0d", want.idx, rsp_result_index);
               failures++;
            end
            if (rsp_available_now !== want.avail) begin
               $error("available_now expected %0d got %0d", want.avail,
                      rsp_available_now);
               failures++;
            end
            if (rsp_semaphore_now !== want.sem) begin
               $error("semaphore_now expected %0d got %0d", want.sem, rsp_semaphore_now);
               failures++;
            end
            if (rsp_head_waiter !== want.head) begin
               $error("head_waiter expected %h got %h", want.head, rsp_head_waiter);
               failures++;
            end
            if (rsp_waiters_empty !== want.empty) begin
               $error("waiters_empty expected %0d got %0d", want.empty,
                      rsp_waiters_empty);
               failures++;
            end
         end
      end
   end

   initial begin
      stim_row_type directed [$];
      outcome_type  none;
      outcome_type  w;
      request_type  rq;
      int           r;
      int           burst;
      int           waited;
      bit           quiet;

      failures = 0;
      responses_seen = 0;
      items_sent = 0;
      table_full_hits = 0;
      list_full_hits = 0;
      created = 0;
      start = 1'b0;
      req_op = OP_CREATE;
      req_resource_index = '0;
      req_instance_count = '0;
      req_with_transfer = 1'b0;
      req_waiter_id = '0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      none = '0;
      w = '0;
      w.status = ST_UNKNOWN;
      // Nothing created yet, and the two undefined op codes.
      directed.push_back(row(OP_RELEASE, 0, 0, 1'b0, '0, 1'b1, w));
      directed.push_back(row(OP_SPARE_HI, 0, 255, 1'b1, '1, 1'b1, w));
      directed.push_back(row(OP_SPARE_LO, 15, 0, 1'b0, '0, 1'b1, w));
      // Creates at both count extremes.
      w = '{ST_OK, 4'd0, 8'd255, 16'sd255, '0, 1'b1};
      directed.push_back(row(OP_CREATE, 9, 255, 1'b1, '1, 1'b1, w));
      w = '{ST_OK, 4'd1, 8'd0, 16'sd0, '0, 1'b1};
      directed.push_back(row(OP_CREATE, 0, 0, 1'b0, '0, 1'b1, w));
      // Acquire with transfer on an empty pool is refused.
      w = '{ST_REFUSED, 4'd1, 8'd0, 16'sd0, '0, 1'b1};
      directed.push_back(row(OP_ACQUIRE, 1, 0, 1'b1, '0, 1'b1, w));
      // Release with transfer cannot exceed the total.
      w = '{ST_OK, 4'd1, 8'd0, 16'sd1, '0, 1'b1};
      directed.push_back(row(OP_RELEASE, 1, 0, 1'b1, '0, 1'b1, w));
      w = '{ST_OK, 4'd0, 8'd255, 16'sd256, '0, 1'b1};
      directed.push_back(row(OP_RELEASE, 0, 0, 1'b1, '0, 1'b1, w));
      directed.push_back(row(OP_ACQUIRE, 0, 0, 1'b1, '0, 1'b0, none));
      directed.push_back(row(OP_ACQUIRE, 0, 0, 1'b0, '0, 1'b0, none));
      // A zero id is never queued.
      w = '{ST_REFUSED, 4'd0, 8'd254, 16'sd255, '0, 1'b1};
      directed.push_back(row(OP_ENQUEUE, 0, 0, 1'b0, '0, 1'b1, w));
      directed.push_back(row(OP_ENQUEUE, 0, 0, 1'b0, '1, 1'b0, none));
      directed.push_back(row(OP_ENQUEUE, 0, 0, 1'b0, 31'd5, 1'b0, none));
      directed.push_back(row(OP_CANCEL, 0, 0, 1'b0, 31'd9, 1'b0, none));
      directed.push_back(row(OP_CANCEL, 0, 0, 1'b0, '0, 1'b0, none));
      directed.push_back(row(OP_CANCEL, 0, 0, 1'b0, 31'd5, 1'b0, none));
      directed.push_back(row(OP_DEQUEUE, 0, 0, 1'b0, '0, 1'b0, none));
      // The list is empty again now.
      w = '{ST_REFUSED, 4'd0, 8'd254, 16'sd256, '0, 1'b1};
      directed.push_back(row(OP_DEQUEUE, 0, 0, 1'b0, '0, 1'b1, w));
      w = '0;
      w.status = ST_UNKNOWN;
      directed.push_back(row(OP_CANCEL, 15, 255, 1'b1, '1, 1'b1, w));

      foreach (directed[k]) issue(directed[k].rq, directed[k].typed, directed[k].want, 0);

      // Random phase. Idle stretches alternate with idle-free ones, and now
      // and then one list is filled to or past capacity, then as many dequeues and cancels follow.
      quiet = 1'b0;
      while (items_sent < 600) begin
         if ($urandom_range(0, 39) == 0) quiet = ~quiet;
         if (created > 0 && $urandom_range(0, 24) == 0) begin
            r = $urandom_range(0, created - 1);
            burst = $urandom_range(NWAIT, NWAIT + 3);
            for (int b = 0; b < burst; b++) begin
               rq = '{OP_ENQUEUE, r[IDX_W-1:0], 8'($urandom), 1'($urandom),
                      31'($urandom_range(1, 6))};
               issue(rq, 1'b0, none, pick_gap(quiet));
            end
            for (int b = 0; b < burst; b++) begin
               rq = '{($urandom_range(0, 1) ? OP_CANCEL : OP_DEQUEUE), r[IDX_W-1:0],
                      8'($urandom), 1'($urandom), 31'($urandom_range(1, 6))};
               issue(rq, 1'b0, none, pick_gap(quiet));
            end
         end else begin
            issue(random_request(), 1'b0, none, pick_gap(quiet));
         end
      end

      // Final phase, without idling.
      while (items_sent < 700) issue(random_request(), 1'b0, none, 0);
      @(negedge clock);
      start <= 1'b0;

      waited = 0;
      while (pending_outcomes.size() != 0 && waited < 10000) begin
         @(posedge clock);
         waited++;
      end
      repeat (3 * NWAIT + 20) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         $error("%0d responses never arrived", pending_outcomes.size());
         failures++;
      end

      $display("Run covered %0d transactions and %0d responses, %0d full-table creates",
               items_sent, responses_seen, table_full_hits);
      $display("and %0d full-list enqueues, with and without idle gaps.",
               list_full_hits);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: counting_semaphore_wait_table_core.f
hdl/csw_pkg.sv
hdl/csw_front.sv
hdl/csw_back.sv
hdl/counting_semaphore_wait_table_core.sv
hdl/csw_checker.sv
tb/testbench.sv
